FILE: hw/rtl/wall_yplus_statistics_defines.svh
// assertion macros for the wall y+ statistics block
`ifndef WALL_YPLUS_STATISTICS_DEFINES_SVH
`define WALL_YPLUS_STATISTICS_DEFINES_SVH
`ifndef SYNTHESIS
`define WYS_ASSERT_IMPLY(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("wall_yplus_statistics: assertion failed");
`define WYS_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("wall_yplus_statistics: assertion failed");
`else
`define WYS_ASSERT_IMPLY(lbl, cond, prop)
`define WYS_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

FILE: hw/rtl/wys_pkg.sv
// shared constants for the wall y+ statistics block
`default_nettype none
package wys_pkg;
	localparam int ACC_W         = 128;
	localparam int SUM_W         = 52;
	localparam int ADDR_W        = 3;
	localparam int MAX_CELLS_DEF = 1048576;
	localparam logic [31:0] RV_RESET = 32'd1048576;
	localparam logic REG_RV = 1'b0;
endpackage
`default_nettype wire

FILE: hw/rtl/wys_alu.sv
// shared wide add/subtract unit with carry out
`default_nettype none
module wys_alu #(
	parameter int W = wys_pkg::ACC_W
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);
	logic [W-1:0] y_inv;
	assign y_inv = sub ? ~y : y;
	// carry high on subtract means x >= y
	assign {carry, sum} = {1'b0, x} + {1'b0, y_inv} + {{W{1'b0}}, sub};
endmodule
`default_nettype wire

FILE: hw/rtl/wall_yplus_statistics.sv
// wall y+ estimator with running sweep statistics
`default_nettype none
// One request is one wall cell; the block removes the wall-normal part of the relative
// velocity and returns y+ = sqrt(|t| * d * reciprocal_viscosity), saturating at full
// scale, together with sweep min, max and mean on the cell flagged by s_tlast. All
// arithmetic runs through one 128-bit add/subtract unit under a sequencer: shift-add
// multiplies one bit per cycle (three 16-step dot terms, three 16-step projections,
// three 40-step squares, 32-step multiplies by distance and by reciprocal viscosity),
// two restoring square roots (40 and 32 steps) and, on the last cell, a 52-step
// restoring division for the mean. When y+ saturates the second root is skipped. A
// finished result waits in the sequencer until the output register is free;
// s_tready is high only while the sequencer is idle. A finished result sits in the
// output register so the next request can be taken while it waits.
module wall_yplus_statistics #(
	parameter int MAX_CELLS = wys_pkg::MAX_CELLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// apb configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [wys_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// cell requests
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// fluid_vel_x, fluid_vel_y, fluid_vel_z, wall_vel_x, wall_vel_y, wall_vel_z,
	// normal_x, normal_y, normal_z, wall_distance
	input  logic [271:0]              s_tdata,
	input  logic                      s_tlast,   // last_cell
	// results
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// y_plus, min_y_plus, max_y_plus, mean_y_plus
	output logic [127:0]              m_tdata,
	output logic                      m_tuser    // stats_valid
);
	localparam int AW    = wys_pkg::ACC_W;
	localparam int SW    = wys_pkg::SUM_W;
	localparam int CNT_W = $clog2(MAX_CELLS + 1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DOT   = 13'b0000000000010,
		S_PROJ  = 13'b0000000000100,
		S_TSUB  = 13'b0000000001000,
		S_TABS  = 13'b0000000010000,
		S_SQR   = 13'b0000000100000,
		S_SQRT1 = 13'b0000001000000,
		S_MULD  = 13'b0000010000000,
		S_MULV  = 13'b0000100000000,
		S_SQRT2 = 13'b0001000000000,
		S_STAT  = 13'b0010000000000,
		S_DIV   = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] rv_q;
	logic        cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == wys_pkg::REG_RV) ? rv_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= wys_pkg::RV_RESET;
		end else if (cfg_wr && paddr[2] == wys_pkg::REG_RV) begin
			rv_q <= pwdata;
		end
	end

	// request fields, relative velocity formed on accept
	logic               s_acc;
	logic signed [32:0] r_in [3];
	logic [15:0]        n_in [3];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_in[i] = $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]})
				- $signed({s_tdata[32*i+127], s_tdata[32*i+96 +: 32]});
			n_in[i] = s_tdata[192+16*i +: 16];
		end
	end

	// datapath registers; r, n and m rotate so element 0 is always the one in use
	logic signed [32:0] r_q [3];
	logic [15:0]        n_q [3];
	logic [39:0]        m_q [3];
	logic [31:0]        d_q;
	logic               last_q;
	logic [47:0]        dq_q;
	logic [AW-1:0]      acc_q;
	logic [AW-1:0]      a_q;
	logic [39:0]        b_q;
	logic [63:0]        root_q;
	logic [6:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               sgn_q;
	logic [31:0]        yp_q;

	// statistics
	logic [31:0]      min_q, max_q;
	logic [SW-1:0]    sum_q;
	logic [CNT_W-1:0] count_q;

	// output register
	logic [31:0] y_o_q, min_o_q, max_o_q, mean_o_q;
	logic        sv_o_q;
	logic        m_valid_q;

	// shared unit operand selection
	logic [AW-1:0] alu_x, alu_y, alu_sum;
	logic          alu_sub, alu_c;
	logic [AW-1:0] sq_rem, dv_rem, acc_nx, acc_sh;
	logic [63:0]   root_nx;
	logic          cnt_end;

	assign sq_rem  = {acc_q[AW-3:0], a_q[AW-1 -: 2]};
	assign dv_rem  = {acc_q[AW-2:0], a_q[AW-1]};
	assign cnt_end = (cnt_q == 7'd1);

	always_comb begin
		alu_x   = acc_q;
		alu_y   = a_q;
		alu_sub = sgn_q & cnt_end;
		case (state_q)
			S_SQRT1, S_SQRT2: begin
				alu_x   = sq_rem;
				alu_y   = {{(AW-66){1'b0}}, root_q, 2'b01};
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_x   = dv_rem;
				alu_y   = {{(AW-CNT_W){1'b0}}, count_q};
				alu_sub = 1'b1;
			end
			S_TSUB: begin
				alu_x   = {{(AW-33){r_q[0][32]}}, r_q[0]};
				alu_y   = $signed(acc_q) >>> 14;
				alu_sub = 1'b1;
			end
			S_TABS: begin
				alu_x   = '0;
				alu_y   = acc_q;
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	wys_alu #(.W(AW)) u_alu (
		.x    (alu_x),
		.y    (alu_y),
		.sub  (alu_sub),
		.sum  (alu_sum),
		.carry(alu_c)
	);

	// multiply step keeps the sum only for a set multiplier bit
	assign acc_nx  = b_q[0] ? alu_sum : acc_q;
	assign acc_sh  = $signed(acc_nx) >>> 14;
	assign root_nx = {root_q[62:0], alu_c};

	logic          upd;
	logic [SW-1:0] sum_nx;
	logic          out_free;
	assign upd      = (count_q < CNT_W'(MAX_CELLS));
	assign sum_nx   = upd ? sum_q + {{(SW-32){1'b0}}, yp_q} : sum_q;
	assign out_free = ~m_valid_q | m_tready;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			min_q     <= '1;
			max_q     <= '0;
			sum_q     <= '0;
			count_q   <= '0;
		end else begin
			// a new result in S_FIN takes priority over draining the old one
			if (m_valid_q && m_tready && state_q != S_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					if (cnt_end && idx_q == 2'd2) begin
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					if (cnt_end) begin
						state_q <= S_TSUB;
					end
				end
				S_TSUB: state_q <= S_TABS;
				S_TABS: state_q <= (idx_q == 2'd2) ? S_SQR : S_PROJ;
				S_SQR: begin
					if (cnt_end && idx_q == 2'd2) begin
						state_q <= S_SQRT1;
					end
				end
				S_SQRT1: begin
					if (cnt_end) begin
						state_q <= S_MULD;
					end
				end
				S_MULD: begin
					if (cnt_end) begin
						state_q <= S_MULV;
					end
				end
				S_MULV: begin
					if (cnt_end) begin
						state_q <= (|acc_nx[AW-1:80]) ? S_STAT : S_SQRT2;
					end
				end
				S_SQRT2: begin
					if (cnt_end) begin
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					if (upd) begin
						if (yp_q < min_q) begin
							min_q <= yp_q;
						end
						if (yp_q > max_q) begin
							max_q <= yp_q;
						end
						sum_q   <= sum_nx;
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= last_q ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (cnt_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
						if (last_q) begin
							min_q   <= '1;
							max_q   <= '0;
							sum_q   <= '0;
							count_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					for (int i = 0; i < 3; i++) begin
						r_q[i] <= r_in[i];
						n_q[i] <= n_in[i];
					end
					d_q    <= s_tdata[271:240];
					last_q <= s_tlast;
					a_q    <= {{(AW-33){r_in[0][32]}}, r_in[0]};
					b_q    <= {24'd0, n_in[0]};
					acc_q  <= AW'(8192);
					cnt_q  <= 7'd16;
					idx_q  <= 2'd0;
					sgn_q  <= 1'b1;
				end
			end
			S_DOT, S_PROJ, S_SQR, S_MULD, S_MULV: begin
				if (!cnt_end || state_q == S_PROJ) begin
					acc_q <= acc_nx;
					a_q   <= {a_q[AW-2:0], 1'b0};
					b_q   <= {1'b0, b_q[39:1]};
					cnt_q <= cnt_q - 7'd1;
				end else begin
					case (state_q)
						S_DOT: begin
							r_q[0] <= r_q[1];
							r_q[1] <= r_q[2];
							r_q[2] <= r_q[0];
							n_q[0] <= n_q[1];
							n_q[1] <= n_q[2];
							n_q[2] <= n_q[0];
							if (idx_q == 2'd2) begin
								// rounded dot product, then first projection
								dq_q  <= acc_sh[47:0];
								a_q   <= acc_sh;
								b_q   <= {24'd0, n_q[1]};
								acc_q <= AW'(8192);
								idx_q <= 2'd0;
							end else begin
								acc_q <= acc_nx;
								a_q   <= {{(AW-33){r_q[1][32]}}, r_q[1]};
								b_q   <= {24'd0, n_q[1]};
								idx_q <= idx_q + 2'd1;
							end
							cnt_q <= 7'd16;
						end
						S_SQR: begin
							m_q[0] <= m_q[1];
							m_q[1] <= m_q[2];
							m_q[2] <= m_q[0];
							if (idx_q == 2'd2) begin
								// |t|^2 placed at the top for the root
								a_q    <= acc_nx << 48;
								acc_q  <= '0;
								root_q <= '0;
								cnt_q  <= 7'd40;
							end else begin
								acc_q <= acc_nx;
								a_q   <= {{(AW-40){1'b0}}, m_q[1]};
								b_q   <= m_q[1];
								cnt_q <= 7'd40;
								idx_q <= idx_q + 2'd1;
							end
						end
						S_MULD: begin
							a_q   <= acc_nx;
							b_q   <= {8'd0, rv_q};
							acc_q <= '0;
							cnt_q <= 7'd32;
						end
						S_MULV: begin
							if (|acc_nx[AW-1:80]) begin
								yp_q <= '1;
							end else begin
								a_q    <= {acc_nx[79:16], 64'd0};
								acc_q  <= '0;
								root_q <= '0;
								cnt_q  <= 7'd32;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_TSUB: acc_q <= alu_sum;
			S_TABS: begin
				m_q[2] <= acc_q[AW-1] ? alu_sum[39:0] : acc_q[39:0];
				m_q[1] <= m_q[2];
				m_q[0] <= m_q[1];
				r_q[0] <= r_q[1];
				r_q[1] <= r_q[2];
				r_q[2] <= r_q[0];
				n_q[0] <= n_q[1];
				n_q[1] <= n_q[2];
				n_q[2] <= n_q[0];
				if (idx_q == 2'd2) begin
					// m_q[1] becomes element 0 after this shift
					a_q   <= {{(AW-40){1'b0}}, m_q[1]};
					b_q   <= m_q[1];
					acc_q <= '0;
					sgn_q <= 1'b0;
					cnt_q <= 7'd40;
					idx_q <= 2'd0;
				end else begin
					a_q   <= {{(AW-48){dq_q[47]}}, dq_q};
					b_q   <= {24'd0, n_q[1]};
					acc_q <= AW'(8192);
					cnt_q <= 7'd16;
					idx_q <= idx_q + 2'd1;
				end
			end
			S_SQRT1, S_SQRT2: begin
				root_q <= root_nx;
				if (!cnt_end) begin
					acc_q <= alu_c ? alu_sum : sq_rem;
					a_q   <= {a_q[AW-3:0], 2'b00};
					cnt_q <= cnt_q - 7'd1;
				end else if (state_q == S_SQRT1) begin
					a_q   <= {{(AW-40){1'b0}}, root_nx[39:0]};
					b_q   <= {8'd0, d_q};
					acc_q <= '0;
					cnt_q <= 7'd32;
				end else begin
					yp_q <= root_nx[31:0];
				end
			end
			S_STAT: begin
				a_q    <= {sum_nx, {(AW-SW){1'b0}}};
				acc_q  <= '0;
				root_q <= '0;
				cnt_q  <= 7'(SW);
			end
			S_DIV: begin
				acc_q  <= alu_c ? alu_sum : dv_rem;
				root_q <= root_nx;
				a_q    <= {a_q[AW-2:0], 1'b0};
				cnt_q  <= cnt_q - 7'd1;
			end
			S_FIN: begin
				if (out_free) begin
					y_o_q    <= yp_q;
					min_o_q  <= last_q ? min_q : 32'd0;
					max_o_q  <= last_q ? max_q : 32'd0;
					mean_o_q <= last_q ? root_q[31:0] : 32'd0;
					sv_o_q   <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {mean_o_q, max_o_q, min_o_q, y_o_q};
	assign m_tuser  = sv_o_q;

`include "wall_yplus_statistics_defines.svh"

	// statistics on a last-cell result are ordered
	`WYS_ASSERT_IMPLY(a_stats_order, m_tvalid && m_tuser, (m_tdata[63:32] <= m_tdata[127:96]) && (m_tdata[127:96] <= m_tdata[95:64]))
	// the count never passes its limit
	`WYS_ASSERT_IMPLY(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_CELLS))
	// an accepted request makes the block busy
	`WYS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the wall y+ estimator with sweep statistics

class yplus_scoreboard;
	typedef struct packed {
		logic [31:0] y_plus;
		logic [31:0] min_y_plus;
		logic [31:0] max_y_plus;
		logic [31:0] mean_y_plus;
		logic        stats_valid;
	} yplus_result_t;

	yplus_result_t pending_results[$];
	logic [31:0] recip_visc;
	logic [31:0] sweep_min;
	logic [31:0] sweep_max;
	logic [51:0] sweep_sum;
	logic [20:0] sweep_count;
	int mismatches;

	function new();
		recip_visc = wys_pkg::RV_RESET;
		sweep_min = '1;
		sweep_max = '0;
		sweep_sum = '0;
		sweep_count = '0;
		mismatches = 0;
	endfunction

	// floor of the square root of a 128-bit value
	function logic [63:0] root_floor(logic [127:0] x);
		logic [63:0] res;
		logic [63:0] c;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= x)
				res = c;
		end
		return res;
	endfunction

	// work out the expected result of one accepted cell
	function void note_cell(logic [2:0][31:0] fluid, logic [2:0][31:0] wall,
			logic [2:0][15:0] nrm, logic [31:0] wall_dist, logic last);
		longint rel[3];
		longint nv[3];
		longint dot;
		longint dq;
		longint tang;
		longint unsigned tmag;
		logic [127:0] sq;
		logic [127:0] prod;
		logic [63:0] tn;
		logic [63:0] yp64;
		logic [31:0] yp;
		yplus_result_t res;
		dot = 0;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			rel[i] = longint'($signed(fluid[i])) - longint'($signed(wall[i]));
			nv[i] = longint'($signed(nrm[i]));
			dot += rel[i] * nv[i];
		end
		// round half up to q16.16, arithmetic shift is a floor
		dq = (dot + 8192) >>> 14;
		for (int i = 0; i < 3; i++) begin
			tang = rel[i] - ((dq * nv[i] + 8192) >>> 14);
			tmag = (tang < 0) ? longint'(-tang) : longint'(tang);
			sq = sq + {64'd0, tmag} * {64'd0, tmag};
		end
		tn = root_floor(sq);
		prod = {64'd0, tn} * {96'd0, wall_dist};
		prod = prod * {96'd0, recip_visc};
		yp64 = root_floor(prod >> 16);
		yp = (yp64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : yp64[31:0];
		if (sweep_count < 21'(wys_pkg::MAX_CELLS_DEF)) begin
			if (yp < sweep_min) sweep_min = yp;
			if (yp > sweep_max) sweep_max = yp;
			sweep_sum = sweep_sum + 52'(yp);
			sweep_count++;
		end
		res = '0;
		res.y_plus = yp;
		if (last) begin
			res.min_y_plus = sweep_min;
			res.max_y_plus = sweep_max;
			res.mean_y_plus = 32'(sweep_sum / 52'(sweep_count));
			res.stats_valid = 1'b1;
			sweep_min = '1;
			sweep_max = '0;
			sweep_sum = '0;
			sweep_count = '0;
		end
		pending_results.push_back(res);
	endfunction

	function void check_result(logic [127:0] data, logic user);
		yplus_result_t got;
		yplus_result_t want;
		got = {data[31:0], data[63:32], data[95:64], data[127:96], user};
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h user %b", data, user);
			return;
		end
		want = pending_results.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp yp %h min %h max %h mean %h sv %b, got yp %h min %h max %h mean %h sv %b",
					want.y_plus, want.min_y_plus, want.max_y_plus, want.mean_y_plus,
					want.stats_valid, got.y_plus, got.min_y_plus, got.max_y_plus,
					got.mean_y_plus, got.stats_valid);
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEMS_PER_PHASE = 240;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [wys_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// fluid x,y,z, wall x,y,z, normal x,y,z, wall_distance
	logic [271:0] s_tdata = '0;
	logic s_tlast = 1'b0;      // last_cell
	logic m_tvalid;
	logic m_tready = 1'b0;
	// y_plus, min_y_plus, max_y_plus, mean_y_plus
	logic [127:0] m_tdata;
	logic m_tuser;             // stats_valid

	yplus_scoreboard sb = new();
	int cycles = 0;
	int stall_left = 0;

	wall_yplus_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: check every accepted result, then pick the next ready level
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			// mostly short stalls, now and then a long one
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one apb write, setup then access phase
	task automatic write_recip_visc(logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= wys_pkg::ADDR_W'(4 * wys_pkg::REG_RV);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.recip_visc = value;
		@(posedge clk);
	endtask

	// present one cell request and hold it until accepted
	task automatic send_cell(logic [2:0][31:0] fluid, logic [2:0][31:0] wall,
			logic [2:0][15:0] nrm, logic [31:0] wall_dist, logic last);
		s_tvalid <= 1'b1;
		s_tdata <= {wall_dist, nrm, wall, fluid};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_cell(fluid, wall, nrm, wall_dist, last);
	endtask

	// random idle time after a request, mostly none
	task automatic sender_gap();
		int gap;
		gap = 0;
		if ($urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
				: $urandom_range(1, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random cell, mostly plausible flow near a wall, some raw noise
	task automatic random_cell(bit last);
		logic [2:0][31:0] fluid;
		logic [2:0][31:0] wall;
		logic [2:0][15:0] nrm;
		logic [31:0] wall_dist;
		int axis;
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < 3; i++) begin
				fluid[i] = $urandom;
				wall[i] = $urandom;
				nrm[i] = $urandom;
			end
			wall_dist = $urandom;
			if (wall_dist == 0) wall_dist = 1;
		end else begin
			axis = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				fluid[i] = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
				wall[i] = ($urandom_range(0, 3) == 0)
					? $urandom_range(0, 32'h0004_0000) - 32'h0002_0000 : 32'd0;
				nrm[i] = (i == axis) ? (($urandom_range(0, 1) == 0) ? 16'sd16384
					: -16'sd16384) : 16'($urandom_range(0, 128)) - 16'd64;
			end
			wall_dist = $urandom_range(1, 32'h0100_0000);
		end
		send_cell(fluid, wall, nrm, wall_dist, last);
	endtask

	// extremes and special cases
	task automatic directed_cells();
		logic [2:0][15:0] unit_z;
		unit_z = {16'sd16384, 16'd0, 16'd0};
		send_cell({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {3{16'h7FFF}}, 32'hFFFF_FFFF,
			1'b0);
		send_cell({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{16'h8000}}, 32'd1, 1'b0);
		send_cell({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, '0, 32'hFFFF_FFFF, 1'b0);
		send_cell('0, '0, unit_z, 32'h0100_0000, 1'b0);
		send_cell({3{32'h0001_0000}}, {3{32'h0001_0000}}, unit_z, 32'h0100_0000, 1'b1);
		// single-cell sweep
		send_cell({32'd0, 32'd0, 32'h0002_0000}, '0, unit_z, 32'h0000_1000, 1'b1);
		// velocity purely along the normal leaves nothing tangential
		send_cell({32'h0005_0000, 32'd0, 32'd0}, '0, unit_z, 32'h0100_0000, 1'b0);
		// non-unit normals
		send_cell({32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, '0, {3{16'h7FFF}},
			32'h0080_0000, 1'b0);
		send_cell({32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000}, '0,
			{16'h1234, 16'hC000, 16'h0001}, 32'h0080_0000, 1'b0);
		send_cell({32'h0001_8000, 32'h0000_0001, 32'hFFFF_FFFF}, {32'h0000_8000, 32'd0, 32'd1},
			{16'd0, 16'sd16384, 16'd0}, 32'hFFFF_FFFF, 1'b0);
		send_cell({32'h0000_0001, 32'd0, 32'd0}, '0, unit_z, 32'd1, 1'b1);
	endtask

	task automatic wait_drained();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [31:0] settings[5];
		settings = '{wys_pkg::RV_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (settings[p]) begin
			write_recip_visc(settings[p]);
			directed_cells();
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				random_cell(k == ITEMS_PER_PHASE - 1 || $urandom_range(0, 15) == 0);
				sender_gap();
			end
			s_tvalid <= 1'b0;
			s_tlast <= 1'b0;
			wait_drained();
		end
		repeat (500) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
